### rtl/spf_pkg.sv
// Shared types and constants for the smallest-prime-factor sieve factorizer.
// Holds the command/status structs between controller and datapath.
`default_nettype none

package spf_pkg;

    localparam int SPF_TABLE_SIZE = 65536;
    localparam int SPF_W          = 16;
    localparam int SPF_MAX_RES    = 15;
    localparam int SPF_CNT_W      = 4;

    // Table depth is capped at the 16-bit query range.
    function automatic int spf_depth(input int table_size);
        return (table_size < 65536) ? table_size : 65536;
    endfunction

    typedef struct packed {
        logic clr_wr;
        logic p_init;
        logic p_read;
        logic p_next;
        logic m_start;
        logic m_step;
        logic q_load;
        logic err_load;
        logic q_read;
        logic div_start;
        logic q_update;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic p_end;
        logic rd_zero;
        logic m_end;
        logic in_bad;
        logic div_done;
        logic res_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

### rtl/spf_sieve_prime_factorizer.sv
// Startup: a sweep zeroes all min(TABLE_SIZE,65536) table entries, one a cycle,
// then the sieve walk fills them; no query is taken meanwhile.
// Query: each prime factor takes a table read plus the 16-step divider,
// up to 15 factors; an error query gives a single word.
// Reset (i_rst_n, synchronous, low) restarts the sweep and the sieve walk.
`default_nettype none

module spf_sieve_prime_factorizer
    import spf_pkg::*;
#(
    parameter int TABLE_SIZE = SPF_TABLE_SIZE
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [SPF_W-1:0] i_value,
    output logic                  o_stall,
    output logic                  o_valid,
    output logic [SPF_W-1:0]      o_factor,
    output logic                  o_last,
    output logic                  o_error,
    input  wire logic             i_stall
);

    t_cmd cmd;
    t_sts sts;

    spf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    spf_dpath #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_value  (i_value),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_factor (o_factor),
        .o_last   (o_last),
        .o_error  (o_error)
    );

endmodule

`default_nettype wire

### rtl/spf_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on spf_pkg for the word width.
`default_nettype none

module spf_div
    import spf_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SPF_W-1:0] i_dividend,
    input  wire logic [SPF_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [SPF_W-1:0]      o_quotient
);

    localparam int STEP_W = $clog2(SPF_W + 1);

    logic [SPF_W-1:0]  r_rem;
    logic [SPF_W-1:0]  r_quo;
    logic [SPF_W-1:0]  r_dvs;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [SPF_W:0]    rem_sh;
    logic              ge;

    assign rem_sh = {r_rem, r_quo[SPF_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(SPF_W);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? SPF_W'(rem_sh - {1'b0, r_dvs}) : SPF_W'(rem_sh);
                r_quo <= {r_quo[SPF_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

### rtl/spf_dpath.sv
// Datapath: factor table memory, sieve counters, quotient, divider, output word.
// Depends on spf_pkg and spf_div; driven by spf_ctrl commands.
`default_nettype none

module spf_dpath
    import spf_pkg::*;
#(
    parameter int TABLE_SIZE = SPF_TABLE_SIZE
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    output t_sts                  o_sts,
    input  wire logic [SPF_W-1:0] i_value,
    input  wire logic             i_stall,
    output logic                  o_valid,
    output logic [SPF_W-1:0]      o_factor,
    output logic                  o_last,
    output logic                  o_error
);

    localparam int DEPTH = spf_depth(TABLE_SIZE);
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int MW    = CW + 1;

    logic [SPF_W-1:0]     r_mem [DEPTH];
    logic [SPF_W-1:0]     r_rdata;
    logic [CW-1:0]        r_idx;
    logic [MW-1:0]        r_m;
    logic [AW-1:0]        r_wm;
    logic                 r_pend;
    logic [SPF_W-1:0]     r_q;
    logic [SPF_W-1:0]     r_f;
    logic [SPF_CNT_W-1:0] r_cnt;
    logic                 r_last;
    logic                 r_err;
    logic                 r_ovalid;
    logic [SPF_W-1:0]     r_ofac;
    logic                 r_olast;
    logic                 r_oerr;

    logic                 m_end;
    logic                 we;
    logic [AW-1:0]        waddr;
    logic [SPF_W-1:0]     wdata;
    logic                 re;
    logic [AW-1:0]        raddr;
    logic [SPF_W-1:0]     f_sel;
    logic                 div_done;
    logic [SPF_W-1:0]     div_quo;

    assign m_end = r_m >= MW'(DEPTH);
    assign f_sel = (r_rdata < SPF_W'(2)) ? r_q : r_rdata;

    // Write port: zero sweep, or mark an unmarked multiple with the prime.
    always_comb begin
        we    = 1'b0;
        waddr = r_idx[AW-1:0];
        wdata = '0;
        if (i_cmd.clr_wr) begin
            we = 1'b1;
        end else if (i_cmd.m_step && r_pend && r_rdata == '0) begin
            we    = 1'b1;
            waddr = r_wm;
            wdata = SPF_W'(r_idx);
        end
    end

    always_comb begin
        re    = 1'b0;
        raddr = r_idx[AW-1:0];
        if (i_cmd.p_read) begin
            re = 1'b1;
        end else if (i_cmd.m_step && !m_end) begin
            re    = 1'b1;
            raddr = r_m[AW-1:0];
        end else if (i_cmd.q_read) begin
            re    = 1'b1;
            raddr = r_q[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= r_mem[raddr];
        end
    end

    spf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_q),
        .i_divisor  (f_sel),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.p_init) begin
                r_idx <= CW'(2);
            end else if (i_cmd.clr_wr || i_cmd.p_next) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.m_start) begin
                r_m    <= MW'(r_idx);
                r_pend <= 1'b0;
            end else if (i_cmd.m_step) begin
                if (!m_end) begin
                    r_pend <= 1'b1;
                    r_wm   <= r_m[AW-1:0];
                    r_m    <= r_m + MW'(r_idx);
                end else begin
                    r_pend <= 1'b0;
                end
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_load) begin
            r_q   <= i_value;
            r_cnt <= '0;
            r_err <= 1'b0;
        end
        if (i_cmd.err_load) begin
            r_f    <= '0;
            r_last <= 1'b1;
            r_err  <= 1'b1;
        end
        if (i_cmd.div_start) begin
            r_f <= f_sel;
        end
        if (i_cmd.q_update) begin
            r_q    <= div_quo;
            r_last <= (div_quo == SPF_W'(1)) || (r_cnt == SPF_CNT_W'(SPF_MAX_RES - 1));
            r_cnt  <= r_cnt + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_ofac  <= r_f;
            r_olast <= r_last;
            r_oerr  <= r_err;
        end
    end

    always_comb begin
        o_sts.clr_last = r_idx == CW'(DEPTH - 1);
        o_sts.p_end    = r_idx == CW'(DEPTH);
        o_sts.rd_zero  = r_rdata == '0;
        o_sts.m_end    = m_end;
        o_sts.in_bad   = (i_value < SPF_W'(2)) || ({1'b0, i_value} >= 17'(DEPTH));
        o_sts.div_done = div_done;
        o_sts.res_last = r_last;
        o_sts.out_free = !r_ovalid || !i_stall;
    end

    assign o_valid  = r_ovalid;
    assign o_factor = r_ofac;
    assign o_last   = r_olast;
    assign o_error  = r_oerr;

    a_div_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> f_sel >= SPF_W'(2))
        else $error("divisor below two");

    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_oerr |-> r_ofac == '0 && r_olast)
        else $error("error word not final or nonzero");

    a_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_ovalid || !i_stall)
        else $error("output word overwritten while held");

endmodule

`default_nettype wire

### rtl/spf_ctrl.sv
// Controller: sequences the table sweep, the sieve walk and each query.
// Depends on spf_pkg; drives spf_dpath through t_cmd and reads t_sts.
`default_nettype none

module spf_ctrl
    import spf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_CLR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_MARK,
        S_IDLE,
        S_Q_RD,
        S_Q_WAIT,
        S_DIV,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    o_cmd.p_init = 1'b1;
                    n_state      = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (i_sts.p_end) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.p_read = 1'b1;
                    n_state      = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (i_sts.rd_zero) begin
                    o_cmd.m_start = 1'b1;
                    n_state       = S_MARK;
                end else begin
                    o_cmd.p_next = 1'b1;
                    n_state      = S_SCAN_RD;
                end
            end
            S_MARK: begin
                o_cmd.m_step = 1'b1;
                if (i_sts.m_end) begin
                    o_cmd.p_next = 1'b1;
                    n_state      = S_SCAN_RD;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    if (i_sts.in_bad) begin
                        o_cmd.err_load = 1'b1;
                        o_cmd.q_load   = 1'b1;
                        n_state        = S_EMIT;
                    end else begin
                        o_cmd.q_load = 1'b1;
                        n_state      = S_Q_RD;
                    end
                end
            end
            S_Q_RD: begin
                o_cmd.q_read = 1'b1;
                n_state      = S_Q_WAIT;
            end
            S_Q_WAIT: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.q_update = 1'b1;
                    n_state        = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = i_sts.res_last ? S_IDLE : S_Q_RD;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = r_state != S_IDLE;

endmodule

`default_nettype wire
